[sv/ook_pulse_width_key_sender_macros.svh]
// Assertion macros for the OOK pulse-width key sender checker.
// Needs nothing else; included by the checker file.
`ifndef OOK_PULSE_WIDTH_KEY_SENDER_MACROS_SVH
`define OOK_PULSE_WIDTH_KEY_SENDER_MACROS_SVH

// Clocked assertion with explicit clock and active-low reset.
`define OOKPWS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's clk_i / rst_ni.
`define OOKPWS_ASSERT(label, prop, msg) \
  `OOKPWS_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

[sv/ookpws_pkg.sv]
// Package for the OOK pulse-width key sender: widths, reset values, register codes.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package ookpws_pkg;

  localparam int KEY_BITS    = 24;
  localparam int KEY_IN_W    = 24;
  localparam int BIT_IDX_W   = $clog2(KEY_BITS + 1);
  localparam int KEY_IDX_W   = $clog2(KEY_BITS);
  localparam int UNIT_W      = 16;
  localparam int GUARD_W     = 16;
  localparam int REPEAT_W    = 8;
  localparam int TICK_W      = UNIT_W + 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [UNIT_W-1:0]   UNIT_RESET   = UNIT_W'(376);
  localparam logic [GUARD_W-1:0]  GUARD_RESET  = GUARD_W'(10600);
  localparam logic [REPEAT_W-1:0] REPEAT_RESET = REPEAT_W'(20);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UNIT_TICKS   = 2'd0,
    CFG_GUARD_TICKS  = 2'd1,
    CFG_REPEAT_COUNT = 2'd2
  } cfg_idx_e;

endpackage

`default_nettype wire

[sv/ookpws_if.sv]
// Handshake interfaces of the OOK pulse-width key sender: item, result, config.
// Depends on ookpws_pkg.
`default_nettype none

interface ookpws_item_if import ookpws_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [KEY_IN_W-1:0] key_pattern;

  modport source (output valid, mode, key_pattern, input ready);
  modport sink   (input valid, mode, key_pattern, output ready);
endinterface

interface ookpws_res_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic burst_done;

  modport source (output valid, line_level, busy_res, burst_done, input ready);
  modport sink   (input valid, line_level, busy_res, burst_done, output ready);
endinterface

interface ookpws_cfg_if import ookpws_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/ook_pulse_width_key_sender.sv]
// Usage:
// in_i carries one item per beat: mode 0 is one timer tick, mode 1 starts a
// burst with key_pattern (ignored while a burst is running or repeat_count is 0).
// res_o returns exactly one beat per item: line_level, busy_res, burst_done.
// cfg_i writes unit_ticks (0), guard_ticks (1), repeat_count (2); it is always
// ready and must only be used while the block is idle. Other indexes are dropped.
// Latency: the result of an item is valid the cycle after its accept.
// Throughput: one item per cycle; the whole step is one pass through the tick
// counter compare and the bit/phase update between the state and result regs.
// A single result register separates the sides: in_i.ready is high while that
// register is empty or being drained, so a stalled res_o holds the pending
// beat and blocks in_i until res_o.ready returns.
// Reset: no burst, result stage empty, registers back to 376 / 10600 / 20.
// Frame: per key bit (MSB first) one = 1 unit low + 3 high, zero = 3 low + 1
// high; then 1 unit low and guard_ticks high; repeated repeat_count times.
`default_nettype none

module ook_pulse_width_key_sender import ookpws_pkg::*; (
  input  wire            clk_i,
  input  wire            rst_ni,
  ookpws_item_if.sink    in_i,
  ookpws_res_if.source   res_o,
  ookpws_cfg_if.sink     cfg_i
);

  logic [UNIT_W-1:0]    unit_q;
  logic [GUARD_W-1:0]   guard_q;
  logic [REPEAT_W-1:0]  repeat_q;

  logic [KEY_BITS-1:0]  key_q,     key_d;
  logic [BIT_IDX_W-1:0] bit_idx_q, bit_idx_d;
  logic                 phase_q,   phase_d;
  logic [TICK_W-1:0]    tick_q,    tick_d;
  logic [REPEAT_W-1:0]  rep_q,     rep_d;
  logic                 sending_q, sending_d;

  logic res_valid_q;
  logic line_q, line_d;
  logic busy_q, busy_d;
  logic done_q, done_d;

  logic                 accept;
  logic [TICK_W-1:0]    unit_eff, guard_eff, three_unit, half_len, tick_inc;
  logic [KEY_IDX_W-1:0] key_idx;
  logic                 key_bit, in_tail;

  assign in_i.ready  = !res_valid_q || res_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign res_o.valid      = res_valid_q;
  assign res_o.line_level = line_q;
  assign res_o.busy_res   = busy_q;
  assign res_o.burst_done = done_q;

  // half length of the current pulse
  assign unit_eff   = (unit_q == '0) ? TICK_W'(1) : TICK_W'(unit_q);
  assign guard_eff  = (guard_q == '0) ? TICK_W'(1) : TICK_W'(guard_q);
  assign three_unit = (unit_eff << 1) + unit_eff;
  assign in_tail    = (bit_idx_q >= BIT_IDX_W'(KEY_BITS));
  assign key_idx    = KEY_IDX_W'(KEY_BITS - 1) - KEY_IDX_W'(bit_idx_q);
  assign key_bit    = key_q[key_idx];
  assign tick_inc   = tick_q + TICK_W'(1);

  always_comb begin
    if (in_tail) begin
      half_len = phase_q ? guard_eff : unit_eff;
    end else if (!phase_q) begin
      half_len = key_bit ? unit_eff : three_unit;
    end else begin
      half_len = key_bit ? three_unit : unit_eff;
    end
  end

  always_comb begin
    key_d     = key_q;
    bit_idx_d = bit_idx_q;
    phase_d   = phase_q;
    tick_d    = tick_q;
    rep_d     = rep_q;
    sending_d = sending_q;
    line_d    = 1'b1;
    busy_d    = 1'b0;
    done_d    = 1'b0;
    if (in_i.mode) begin
      if (!sending_q && repeat_q != '0) begin
        key_d     = KEY_BITS'(in_i.key_pattern);
        bit_idx_d = '0;
        phase_d   = 1'b0;
        tick_d    = '0;
        rep_d     = repeat_q;
        sending_d = 1'b1;
        line_d    = 1'b0;
        busy_d    = 1'b1;
      end else if (sending_q) begin
        line_d = phase_q;
        busy_d = 1'b1;
      end
    end else if (sending_q) begin
      line_d = phase_q;
      busy_d = 1'b1;
      if (tick_inc >= half_len) begin
        tick_d = '0;
        if (!phase_q) begin
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          if (in_tail) begin
            bit_idx_d = '0;
            rep_d     = rep_q - REPEAT_W'(1);
            if (rep_d == '0) begin
              sending_d = 1'b0;
              done_d    = 1'b1;
            end
          end else begin
            bit_idx_d = bit_idx_q + BIT_IDX_W'(1);
          end
        end
      end else begin
        tick_d = tick_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q   <= UNIT_RESET;
      guard_q  <= GUARD_RESET;
      repeat_q <= REPEAT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_UNIT_TICKS:   unit_q   <= UNIT_W'(cfg_i.data);
        CFG_GUARD_TICKS:  guard_q  <= GUARD_W'(cfg_i.data);
        CFG_REPEAT_COUNT: repeat_q <= REPEAT_W'(cfg_i.data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      bit_idx_q <= '0;
      phase_q   <= 1'b0;
      tick_q    <= '0;
      rep_q     <= '0;
      sending_q <= 1'b0;
    end else if (accept) begin
      key_q     <= key_d;
      bit_idx_q <= bit_idx_d;
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      rep_q     <= rep_d;
      sending_q <= sending_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_q <= line_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

endmodule

`default_nettype wire

[sv/ookpws_checker.sv]
// Port-level checker for the OOK pulse-width key sender, bound to the top level.
// Depends on ook_pulse_width_key_sender_macros.svh.
`default_nettype none
`include "ook_pulse_width_key_sender_macros.svh"

module ookpws_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire in_valid_i,
  input wire in_ready_i,
  input wire res_valid_i,
  input wire res_ready_i,
  input wire res_line_i,
  input wire res_busy_i,
  input wire res_done_i
);

  `OOKPWS_ASSERT(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_line_i) && $stable(res_busy_i) && $stable(res_done_i), "stalled result beat changed")
  `OOKPWS_ASSERT(a_done_busy, res_valid_i && res_done_i |-> res_busy_i, "burst_done without busy")
  `OOKPWS_ASSERT(a_idle_high, res_valid_i && !res_busy_i |-> res_line_i, "line low while idle")
  `OOKPWS_ASSERT(a_ready_empty, !res_valid_i |-> in_ready_i, "input blocked with empty result stage")
  `OOKPWS_ASSERT(a_res_follows, in_valid_i && in_ready_i |=> res_valid_i, "accepted item gave no result beat")

endmodule

bind ook_pulse_width_key_sender ookpws_checker u_ookpws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_line_i  (res_o.line_level),
  .res_busy_i  (res_o.busy_res),
  .res_done_i  (res_o.burst_done)
);

`default_nettype wire

[sim/ook_pulse_width_key_sender_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the OOK pulse-width key sender: a directed table, then random
// bursts under random valid/ready idling, results checked against typed rows or a predictor.
// Depends on ookpws_pkg, the ookpws interfaces and ook_pulse_width_key_sender.

module ook_pulse_width_key_sender_tb;
  import ookpws_pkg::*;

  typedef struct packed {
    logic level;
    logic busy;
    logic done;
  } line_beat_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG, ROW_DRAIN} row_kind_e;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;

  localparam line_beat_t IDLE_BEAT = '{1'b1, 1'b0, 1'b0};
  localparam line_beat_t LOW_BUSY  = '{1'b0, 1'b1, 1'b0};
  localparam line_beat_t HIGH_BUSY = '{1'b1, 1'b1, 1'b0};

  typedef struct packed {
    row_kind_e             kind;
    logic                  mode;
    logic [KEY_IN_W-1:0]   key;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;
    logic                  typed;
    line_beat_t            want;
  } row_t;

  localparam int N_ROWS = 37;
  localparam row_t DIRECTED [N_ROWS] = '{
    '{ROW_ITEM,  MODE_TICK,  24'h000000, CFG_UNUSED,       16'h0000, 1'b1, IDLE_BEAT},
    '{ROW_CFG,   MODE_TICK,  24'h000000, CFG_UNIT_TICKS,   16'h0001, 1'b0, IDLE_BEAT},
    '{ROW_CFG,   MODE_TICK,  24'h000000, CFG_GUARD_TICKS,  16'h0001, 1'b0, IDLE_BEAT},
    // repeat count still at its reset value here
    '{ROW_ITEM,  MODE_START, 24'hFFFFFF, CFG_UNUSED,       16'h0000, 1'b1, LOW_BUSY},
    '{ROW_DRAIN, MODE_TICK,  24'h000000, CFG_UNUSED,       16'h0000, 1'b0, IDLE_BEAT},
    // zero repeat count: start is dropped
    '{ROW_CFG,   MODE_TICK,  24'h000000, CFG_REPEAT_COUNT, 16'h0000, 1'b0, IDLE_BEAT},
    '{ROW_ITEM,  MODE_START, 24'hFFFFFF, CFG_UNUSED,       16'h0000, 1'b1, IDLE_BEAT},
    '{ROW_ITEM,  MODE_TICK,  24'hFFFFFF, CFG_UNUSED,       16'h0000, 1'b1, IDLE_BEAT},
    // zero unit and guard act as one tick
    '{ROW_CFG,   MODE_TICK,  24'h000000, CFG_UNIT_TICKS,   16'h0000, 1'b0, IDLE_BEAT},
    '{ROW_CFG,   MODE_TICK,  24'h000000, CFG_GUARD_TICKS,  16'h0000, 1'b0, IDLE_BEAT},
    '{ROW_CFG,   MODE_TICK,  24'h000000, CFG_REPEAT_COUNT, 16'h0001, 1'b0, IDLE_BEAT},
    '{ROW_ITEM,  MODE_START, 24'h800000, CFG_UNUSED,       16'h0000, 1'b1, LOW_BUSY},
    // start while busy is dropped, in both halves
    '{ROW_ITEM,  MODE_START, 24'h000000, CFG_UNUSED,       16'h0000, 1'b1, LOW_BUSY},
    '{ROW_ITEM,  MODE_TICK,  24'h000000, CFG_UNUSED,       16'h0000, 1'b1, LOW_BUSY},
    '{ROW_ITEM,  MODE_TICK,  24'hFFFFFF, CFG_UNUSED,       16'h0000, 1'b1, HIGH_BUSY},
    '{ROW_ITEM,  MODE_START, 24'h123456, CFG_UNUSED,       16'h0000, 1'b1, HIGH_BUSY},
    '{ROW_DRAIN, MODE_TICK,  24'h000000, CFG_UNUSED,       16'h0000, 1'b0, IDLE_BEAT},
    '{ROW_CFG,   MODE_TICK,  24'h000000, CFG_UNIT_TICKS,   16'hFFFF, 1'b0, IDLE_BEAT},
    '{ROW_CFG,   MODE_TICK,  24'h000000, CFG_GUARD_TICKS,  16'hFFFF, 1'b0, IDLE_BEAT},
    '{ROW_CFG,   MODE_TICK,  24'h000000, CFG_REPEAT_COUNT, 16'h00FF, 1'b0, IDLE_BEAT},
    '{ROW_CFG,   MODE_TICK,  24'h000000, CFG_UNUSED,       16'hFFFF, 1'b0, IDLE_BEAT},
    '{ROW_ITEM,  MODE_TICK,  24'h000000, CFG_UNUSED,       16'h0000, 1'b1, IDLE_BEAT},
    // long guard time
    '{ROW_CFG,   MODE_TICK,  24'h000000, CFG_UNIT_TICKS,   16'h0001, 1'b0, IDLE_BEAT},
    '{ROW_CFG,   MODE_TICK,  24'h000000, CFG_GUARD_TICKS,  16'h0040, 1'b0, IDLE_BEAT},
    '{ROW_CFG,   MODE_TICK,  24'h000000, CFG_REPEAT_COUNT, 16'h0001, 1'b0, IDLE_BEAT},
    '{ROW_ITEM,  MODE_START, 24'h000000, CFG_UNUSED,       16'h0000, 1'b1, LOW_BUSY},
    '{ROW_DRAIN, MODE_TICK,  24'h000000, CFG_UNUSED,       16'h0000, 1'b0, IDLE_BEAT},
    // several frames per burst
    '{ROW_CFG,   MODE_TICK,  24'h000000, CFG_GUARD_TICKS,  16'h0001, 1'b0, IDLE_BEAT},
    '{ROW_CFG,   MODE_TICK,  24'h000000, CFG_REPEAT_COUNT, 16'h0004, 1'b0, IDLE_BEAT},
    '{ROW_ITEM,  MODE_START, 24'hA5A5A5, CFG_UNUSED,       16'h0000, 1'b0, IDLE_BEAT},
    '{ROW_DRAIN, MODE_TICK,  24'h000000, CFG_UNUSED,       16'h0000, 1'b0, IDLE_BEAT},
    '{ROW_CFG,   MODE_TICK,  24'h000000, CFG_UNIT_TICKS,   16'h0003, 1'b0, IDLE_BEAT},
    '{ROW_CFG,   MODE_TICK,  24'h000000, CFG_GUARD_TICKS,  16'h0002, 1'b0, IDLE_BEAT},
    '{ROW_CFG,   MODE_TICK,  24'h000000, CFG_REPEAT_COUNT, 16'h0002, 1'b0, IDLE_BEAT},
    '{ROW_ITEM,  MODE_START, 24'h5A5A5A, CFG_UNUSED,       16'h0000, 1'b0, IDLE_BEAT},
    '{ROW_ITEM,  MODE_TICK,  24'h000000, CFG_UNUSED,       16'h0000, 1'b0, IDLE_BEAT},
    '{ROW_DRAIN, MODE_TICK,  24'h000000, CFG_UNUSED,       16'h0000, 1'b0, IDLE_BEAT}
  };

  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PHASE = 205;

  logic clk;
  logic rst_n;
  bit   idle_on = 1'b0;
  int   mismatches = 0;

  line_beat_t beats_due[$];

  logic [UNIT_W-1:0]    cfg_unit;
  logic [GUARD_W-1:0]   cfg_guard;
  logic [REPEAT_W-1:0]  cfg_repeat;
  logic [KEY_BITS-1:0]  key_sr;
  logic [BIT_IDX_W-1:0] bit_pos;
  logic                 in_high;
  logic [TICK_W-1:0]    ticks_in_half;
  logic [REPEAT_W-1:0]  frames_left;
  logic                 bursting;

  ookpws_item_if item_if ();
  ookpws_res_if  res_if ();
  ookpws_cfg_if  cfg_if ();

  ook_pulse_width_key_sender DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (item_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [TICK_W-1:0] half_ticks();
    logic [TICK_W-1:0] u;
    logic [TICK_W-1:0] g;
    logic              one;
    u = (cfg_unit == '0) ? TICK_W'(1) : TICK_W'(cfg_unit);
    g = (cfg_guard == '0) ? TICK_W'(1) : TICK_W'(cfg_guard);
    if (bit_pos >= KEY_BITS) return in_high ? g : u;
    one = key_sr[KEY_BITS - 1 - int'(bit_pos)];
    if (!in_high) return one ? u : TICK_W'(3) * u;
    return one ? TICK_W'(3) * u : u;
  endfunction

  function automatic line_beat_t next_line_beat(logic mode, logic [KEY_IN_W-1:0] key);
    line_beat_t b;
    b = IDLE_BEAT;
    if (mode == MODE_START) begin
      if (!bursting && cfg_repeat != '0) begin
        key_sr        = KEY_BITS'(key);
        bit_pos       = '0;
        in_high       = 1'b0;
        ticks_in_half = '0;
        frames_left   = cfg_repeat;
        bursting      = 1'b1;
      end
      if (bursting) b = '{in_high, 1'b1, 1'b0};
    end else if (bursting) begin
      b = '{in_high, 1'b1, 1'b0};
      ticks_in_half = ticks_in_half + 1'b1;
      if (ticks_in_half >= half_ticks()) begin
        ticks_in_half = '0;
        if (!in_high) begin
          in_high = 1'b1;
        end else begin
          in_high = 1'b0;
          if (bit_pos >= KEY_BITS) begin
            bit_pos     = '0;
            frames_left = frames_left - 1'b1;
            if (frames_left == '0) begin
              bursting = 1'b0;
              b.done   = 1'b1;
            end
          end else begin
            bit_pos = bit_pos + 1'b1;
          end
        end
      end
    end
    return b;
  endfunction

  task automatic send_item(logic mode, logic [KEY_IN_W-1:0] key, logic typed, line_beat_t want);
    int         gap;
    line_beat_t b;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.valid       <= 1'b1;
    item_if.mode        <= mode;
    item_if.key_pattern <= key;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    b = next_line_beat(mode, key);
    beats_due.push_back(typed ? want : b);
  endtask

  // stop sending and let every pending result beat come back
  task automatic settle();
    item_if.valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_out_burst();
    while (bursting) send_item(MODE_TICK, KEY_IN_W'($urandom), 1'b0, IDLE_BEAT);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_UNIT_TICKS:   cfg_unit   = val[UNIT_W-1:0];
      CFG_GUARD_TICKS:  cfg_guard  = val[GUARD_W-1:0];
      CFG_REPEAT_COUNT: cfg_repeat = val[REPEAT_W-1:0];
      default: ;
    endcase
  endtask

  // result side: random stalls, then check each beat against the oldest expectation
  initial begin
    int         stall;
    line_beat_t got;
    line_beat_t want;
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
      got = '{res_if.line_level, res_if.busy_res, res_if.burst_done};
      if (beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: level=%b busy=%b done=%b",
                   got.level, got.busy, got.done);
      end else begin
        want = beats_due.pop_front();
        if (got.level !== want.level || got.busy !== want.busy || got.done !== want.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch at %0t: expected level=%b busy=%b done=%b, got %b %b %b",
                     $realtime, want.level, want.busy, want.done,
                     got.level, got.busy, got.done);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    row_t r;
    int   pause_at;
    logic start_it;
    cfg_unit      = UNIT_RESET;
    cfg_guard     = GUARD_RESET;
    cfg_repeat    = REPEAT_RESET;
    key_sr        = '0;
    bit_pos       = '0;
    in_high       = 1'b0;
    ticks_in_half = '0;
    frames_left   = '0;
    bursting      = 1'b0;

    rst_n               <= 1'b0;
    item_if.valid       <= 1'b0;
    item_if.mode        <= MODE_TICK;
    item_if.key_pattern <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= CFG_UNIT_TICKS;
    cfg_if.data         <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < N_ROWS; k++) begin
      r = DIRECTED[k];
      case (r.kind)
        ROW_ITEM:  send_item(r.mode, r.key, r.typed, r.want);
        ROW_CFG:   write_reg(r.idx, r.wdata);
        ROW_DRAIN: run_out_burst();
        default: ;
      endcase
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      write_reg(CFG_UNIT_TICKS,
                ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 4)));
      write_reg(CFG_GUARD_TICKS,
                ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 6)));
      write_reg(CFG_REPEAT_COUNT,
                ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 3)));
      pause_at = $urandom_range(0, ITEMS_PER_PHASE - 1);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        start_it = bursting ? ($urandom_range(0, 49) == 0) : ($urandom_range(0, 3) == 0);
        send_item(start_it ? MODE_START : MODE_TICK, KEY_IN_W'($urandom), 1'b0, IDLE_BEAT);
        if (i == pause_at) settle();
      end
      run_out_burst();
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
